/* hdl/jddm_pkg.sv */
// Shared types, field widths and codes for the joystick differential drive mixer.
`default_nettype none

package jddm_pkg;

	localparam int SAMPLE_W = 12;
	localparam int DB_W     = 8;
	localparam int SUM_W    = 18;
	localparam int COUNT_W  = 6;
	localparam int PHASE_W  = 2;
	localparam int DIR_W    = 2;
	localparam int DUTY_W   = 12;
	localparam int CUT_W    = 7;
	localparam int IN_W     = 32;
	localparam int OUT_W    = 32;

	localparam logic [PHASE_W-1:0] PH_WAIT  = 2'd0;
	localparam logic [PHASE_W-1:0] PH_CAL   = 2'd1;
	localparam logic [PHASE_W-1:0] PH_DRIVE = 2'd2;

	localparam logic [DIR_W-1:0] DIR_IDLE = 2'd0;
	localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

	localparam logic [DB_W-1:0]   DB_RESET = 8'd10;
	localparam logic [DUTY_W-1:0] DUTY_MAX = 12'd4095;
	localparam logic [CUT_W-1:0]  CUT_TOP  = 7'd100;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic    button;
		sample_t y_sample;
		sample_t x_sample;
	} report_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  right_duty;
		logic [DUTY_W-1:0]  left_duty;
		logic [DIR_W-1:0]   direction;
		logic [PHASE_W-1:0] phase;
	} result_t;

endpackage

`default_nettype wire

/* hdl/joystick_differential_drive_mixer_unit.sv */
// Joystick mixer: center calibration, dead band and differential duty with a bit-serial divider.
//
//   channel | dir | fields (lsb first)                       | beat when
//   s_      | in  | x_sample, y_sample, button               | s_tvalid & s_tready
//   m_      | out | phase, direction, left_duty, right_duty  | m_tvalid & m_tready
//   cfg_    | in  | dead_band                                | cfg_we
//
// A waiting or calibrating report goes straight to emit; the last calibration report
// adds two divisions of the sums. A driving report runs up to three divisions
// (x ramp, y ramp, duty cut) on the restoring divider that yields one quotient
// bit per cycle and serves all five divisions. Reset clears the control state;
// a result held by a stalled m_ side blocks s_ only once the next result waits to emit.
`default_nettype none

module joystick_differential_drive_mixer_unit #(
	parameter int CAL_SAMPLES = 50,
	parameter int FULL_SCALE  = 4095
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [jddm_pkg::IN_W-1:0]   s_tdata,   // x_sample, y_sample, button
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [jddm_pkg::OUT_W-1:0]       m_tdata,   // phase, direction, left_duty, right_duty
	input  wire logic                        cfg_we,
	input  wire logic [jddm_pkg::DB_W-1:0]   cfg_wdata
);
	import jddm_pkg::*;

	localparam int FS_W     = $clog2(FULL_SCALE + 1);
	localparam int DEN_W    = (FS_W > SAMPLE_W) ? FS_W : SAMPLE_W;
	localparam int NUM_W    = SAMPLE_W + FS_W;
	localparam int HI_W     = ((FS_W > SAMPLE_W + 1) ? FS_W : SAMPLE_W + 1) + 1;
	localparam int K_RAMP_X = FS_W;
	localparam int K_RAMP_Y = CUT_W;
	localparam int K_CUT    = DUTY_W;
	localparam int K_CAL    = SUM_W;
	localparam int K_MAX    = (FS_W > SUM_W) ? FS_W : SUM_W;
	localparam int CNT_W    = $clog2(K_MAX + 1);
	localparam int REP_W    = $bits(report_t);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_LOAD = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_POST = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	localparam logic [1:0] ST_CX   = 2'd0;
	localparam logic [1:0] ST_CY   = 2'd1;
	localparam logic [1:0] ST_RAMP = 2'd2;
	localparam logic [1:0] ST_CUT  = 2'd3;

	localparam logic [DEN_W-1:0] FS_D = DEN_W'(FULL_SCALE);
	localparam logic [HI_W-1:0]  FS_E = HI_W'(FULL_SCALE);

	// control state
	logic [2:0]         state_q;
	logic [1:0]         step_q;
	logic               axis_q;
	logic               down_q;
	logic               hi_side_q;
	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] shown_q;
	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   x_sum_q;
	logic [SUM_W-1:0]   y_sum_q;
	sample_t            x_centre_q;
	sample_t            y_centre_q;
	logic [DIR_W-1:0]   dir_q;
	logic [DB_W-1:0]    dead_band_q;
	logic               m_valid_q;
	logic [CNT_W-1:0]   cnt_q;

	// datapath
	sample_t            x_q;
	sample_t            y_q;
	sample_t            num_q;
	logic [DEN_W-1:0]   den_q;
	logic [DUTY_W-1:0]  duty_q;
	logic [CUT_W-1:0]   cut_q;
	logic [DUTY_W-1:0]  left_q;
	logic [DUTY_W-1:0]  right_q;
	logic [DEN_W-1:0]   rem_q;
	logic [NUM_W-1:0]   dq_q;
	logic [DEN_W-1:0]   d_q;
	result_t            out_q;

	report_t            in_w;
	logic               accept;
	logic [COUNT_W-1:0] count_nx;

	sample_t            v;
	sample_t            c;
	logic [SAMPLE_W:0]  hi;
	sample_t            lo;
	logic [HI_W-1:0]    hi_e;
	logic [HI_W-1:0]    den_e;
	sample_t            up_num;
	logic               go_up;
	logic               go_down;
	logic               up_sat;

	logic [NUM_W-1:0]   mul_a;
	logic [NUM_W-1:0]   mul_b;
	logic [NUM_W-1:0]   prod;
	logic [DEN_W-1:0]   ld_rem;
	logic [NUM_W-1:0]   ld_dq;
	logic [DEN_W-1:0]   ld_d;
	logic [CNT_W-1:0]   ld_cnt;

	logic [DEN_W:0]     trial;
	logic [DEN_W:0]     diff;
	logic               ge;
	logic [DEN_W-1:0]   rem_nx;
	logic [NUM_W-1:0]   dq_nx;

	logic [DEN_W-1:0]   q_den;
	logic [DEN_W-1:0]   x_raw;
	logic [DUTY_W-1:0]  x_duty;
	logic [CUT_W-1:0]   cut_post;
	logic [DUTY_W-1:0]  red;

	assign in_w     = report_t'(s_tdata[REP_W-1:0]);
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign count_nx = count_q + COUNT_W'(1);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'(out_q);

	// dead band compare and ramp operands for the selected axis
	always_comb begin
		v       = axis_q ? y_q : x_q;
		c       = axis_q ? y_centre_q : x_centre_q;
		hi      = {1'b0, c} + (SAMPLE_W + 1)'(dead_band_q);
		lo      = c - SAMPLE_W'(dead_band_q);
		hi_e    = HI_W'(hi);
		den_e   = FS_E - hi_e;
		up_num  = v - hi[SAMPLE_W-1:0];
		go_up   = ({1'b0, v} > hi);
		go_down = (c >= SAMPLE_W'(dead_band_q)) && (v < lo);
		up_sat  = (FS_E <= hi_e) || (DEN_W'(up_num) >= den_e[DEN_W-1:0]);
	end

	// divider load: one shared multiplier, then split at the quotient width
	always_comb begin
		mul_a = NUM_W'(num_q);
		mul_b = axis_q ? NUM_W'(CUT_TOP) : NUM_W'(FULL_SCALE);
		if (step_q == ST_CUT) begin
			mul_a = NUM_W'(duty_q);
			mul_b = NUM_W'(cut_q);
		end
		prod = mul_a * mul_b;
		unique case (step_q)
			ST_CX: begin
				ld_rem = DEN_W'(NUM_W'(x_sum_q) >> K_CAL);
				ld_dq  = NUM_W'(x_sum_q) << (NUM_W - K_CAL);
				ld_d   = DEN_W'(CAL_SAMPLES);
				ld_cnt = CNT_W'(K_CAL);
			end
			ST_CY: begin
				ld_rem = DEN_W'(NUM_W'(y_sum_q) >> K_CAL);
				ld_dq  = NUM_W'(y_sum_q) << (NUM_W - K_CAL);
				ld_d   = DEN_W'(CAL_SAMPLES);
				ld_cnt = CNT_W'(K_CAL);
			end
			ST_RAMP: begin
				if (axis_q) begin
					ld_rem = DEN_W'(prod >> K_RAMP_Y);
					ld_dq  = prod << (NUM_W - K_RAMP_Y);
					ld_cnt = CNT_W'(K_RAMP_Y);
				end else begin
					ld_rem = DEN_W'(prod >> K_RAMP_X);
					ld_dq  = prod << (NUM_W - K_RAMP_X);
					ld_cnt = CNT_W'(K_RAMP_X);
				end
				ld_d = den_q;
			end
			ST_CUT: begin
				ld_rem = DEN_W'(prod >> K_CUT);
				ld_dq  = prod << (NUM_W - K_CUT);
				ld_d   = DEN_W'(CUT_TOP);
				ld_cnt = CNT_W'(K_CUT);
			end
			default: begin
				ld_rem = '0;
				ld_dq  = '0;
				ld_d   = '0;
				ld_cnt = '0;
			end
		endcase
	end

	// one restoring step
	always_comb begin
		trial  = {rem_q, dq_q[NUM_W-1]};
		diff   = trial - {1'b0, d_q};
		ge     = (trial >= {1'b0, d_q});
		rem_nx = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		dq_nx  = {dq_q[NUM_W-2:0], ge};
	end

	// quotient post-processing
	always_comb begin
		q_den    = dq_q[DEN_W-1:0];
		x_raw    = (state_q == S_POST) ? (down_q ? FS_D - q_den : q_den) : FS_D;
		x_duty   = (x_raw > DEN_W'(DUTY_MAX)) ? DUTY_MAX : x_raw[DUTY_W-1:0];
		cut_post = down_q ? CUT_TOP - dq_q[CUT_W-1:0] : dq_q[CUT_W-1:0];
		red      = duty_q - dq_q[DUTY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_CX;
			axis_q      <= 1'b0;
			down_q      <= 1'b0;
			hi_side_q   <= 1'b0;
			phase_q     <= PH_WAIT;
			shown_q     <= PH_WAIT;
			count_q     <= '0;
			x_sum_q     <= '0;
			y_sum_q     <= '0;
			x_centre_q  <= '0;
			y_centre_q  <= '0;
			dir_q       <= DIR_IDLE;
			dead_band_q <= DB_RESET;
			m_valid_q   <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				dead_band_q <= cfg_wdata;
			end
			if (m_valid_q && m_tready && state_q != S_EMIT) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (phase_q == PH_DRIVE) begin
							shown_q <= PH_DRIVE;
							axis_q  <= 1'b0;
							state_q <= S_PREP;
						end else if (phase_q == PH_CAL || in_w.button) begin
							shown_q <= PH_CAL;
							phase_q <= PH_CAL;
							x_sum_q <= x_sum_q + SUM_W'(in_w.x_sample);
							y_sum_q <= y_sum_q + SUM_W'(in_w.y_sample);
							count_q <= count_nx;
							if (count_nx >= COUNT_W'(CAL_SAMPLES)) begin
								step_q  <= ST_CX;
								state_q <= S_LOAD;
							end else begin
								state_q <= S_EMIT;
							end
						end else begin
							shown_q <= PH_WAIT;
							state_q <= S_EMIT;
						end
					end
				end
				S_PREP: begin
					if (!axis_q) begin
						if (go_up) begin
							dir_q  <= DIR_FWD;
							down_q <= 1'b0;
							if (up_sat) begin
								axis_q <= 1'b1;
							end else begin
								step_q  <= ST_RAMP;
								state_q <= S_LOAD;
							end
						end else if (go_down) begin
							dir_q   <= DIR_REV;
							down_q  <= 1'b1;
							step_q  <= ST_RAMP;
							state_q <= S_LOAD;
						end else begin
							axis_q <= 1'b1;
						end
					end else begin
						if (go_up) begin
							hi_side_q <= 1'b1;
							down_q    <= 1'b0;
							step_q    <= up_sat ? ST_CUT : ST_RAMP;
							state_q   <= S_LOAD;
						end else if (go_down) begin
							hi_side_q <= 1'b0;
							down_q    <= 1'b1;
							step_q    <= ST_RAMP;
							state_q   <= S_LOAD;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_LOAD: begin
					cnt_q   <= ld_cnt;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					unique case (step_q)
						ST_CX: begin
							x_centre_q <= dq_q[SAMPLE_W-1:0];
							step_q     <= ST_CY;
							state_q    <= S_LOAD;
						end
						ST_CY: begin
							y_centre_q <= dq_q[SAMPLE_W-1:0];
							phase_q    <= PH_DRIVE;
							state_q    <= S_EMIT;
						end
						ST_RAMP: begin
							if (!axis_q) begin
								axis_q  <= 1'b1;
								state_q <= S_PREP;
							end else begin
								step_q  <= ST_CUT;
								state_q <= S_LOAD;
							end
						end
						ST_CUT: begin
							state_q <= S_EMIT;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_EMIT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					x_q     <= in_w.x_sample;
					y_q     <= in_w.y_sample;
					left_q  <= '0;
					right_q <= '0;
				end
			end
			S_PREP: begin
				num_q <= go_up ? up_num : v;
				den_q <= go_up ? den_e[DEN_W-1:0] : DEN_W'(lo);
				if (!axis_q) begin
					duty_q <= (go_up && up_sat) ? x_duty : '0;
				end else begin
					left_q  <= duty_q;
					right_q <= duty_q;
					if (go_up && up_sat) begin
						cut_q <= CUT_TOP;
					end
				end
			end
			S_LOAD: begin
				rem_q <= ld_rem;
				dq_q  <= ld_dq;
				d_q   <= ld_d;
			end
			S_DIV: begin
				rem_q <= rem_nx;
				dq_q  <= dq_nx;
			end
			S_POST: begin
				if (step_q == ST_RAMP) begin
					if (!axis_q) begin
						duty_q <= x_duty;
					end else begin
						cut_q <= cut_post;
					end
				end else if (step_q == ST_CUT) begin
					if (hi_side_q) begin
						right_q <= red;
					end else begin
						left_q <= red;
					end
				end
			end
			S_EMIT: begin
				if (!m_valid_q || m_tready) begin
					out_q.phase      <= shown_q;
					out_q.direction  <= dir_q;
					out_q.left_duty  <= left_q;
					out_q.right_duty <= right_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* hdl/jddm_checker.sv */
// Port-level checks on the mixer's result beats, bound to the top level.
`default_nettype none

module jddm_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [jddm_pkg::OUT_W-1:0] m_tdata
);
	import jddm_pkg::*;

	result_t r;

	assign r = result_t'(m_tdata[$bits(result_t)-1:0]);

	// no motion outside driving
	a_idle_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.phase != PH_DRIVE |-> r.left_duty == '0 && r.right_duty == '0)
		else $error("nonzero duty outside driving");

	a_wait_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.phase == PH_WAIT |-> r.direction == DIR_IDLE)
		else $error("direction set while waiting");

	a_duty_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (r.left_duty != '0 || r.right_duty != '0)
		|-> r.direction == DIR_FWD || r.direction == DIR_REV)
		else $error("duty without a direction");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled beat changed");

endmodule

bind joystick_differential_drive_mixer_unit jddm_checker u_jddm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
